// File: hdl/sit_pkg.sv
// sit_pkg: shared types and constants for the sorted record table
// holds the table entry layout, status codes and sequencer states
// no dependencies
package sit_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [2:0] STATUS_INSERTED  = 3'd0;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_READ_OK   = 3'd3;
  localparam logic [2:0] STATUS_EMPTY     = 3'd4;

  localparam logic ACTION_INSERT = 1'b0;
  localparam logic ACTION_READ   = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] start_ms;
    logic [31:0] finish_ms;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SH_CMP,
    S_SH_PUT,
    S_RD_WAIT
  } state_t;

endpackage

// File: hdl/sorted_insert_table_with_dup_check.sv
// sorted_insert_table_with_dup_check: top level of the sorted record table
// depends on sit_pkg and sit_ram
//
// usage:
//   a request is taken when start is high and busy is low. action selects an
//   insert (athlete_id, start_ms, finish_ms) or a read of the entry at
//   read_rank. every request gives exactly one result, shown for one cycle
//   with done high: status, out_id, out_start_ms, out_finish_ms and
//   entry_count (records held after the request).
//   busy stays high from the cycle after a request until the result cycle;
//   a new request may be given in the cycle done is high.
// sequence of a request:
//   read: the entry at read_rank is read from the table memory, then shown.
//   insert: an id scan over the table memory; a duplicate is rejected as soon
//   as the scan meets its id, a full table when the scan ends. else each
//   record with a later finish time is moved up one place and the new one is
//   placed, then the result is shown. an empty table skips the scan and moves.
//   the one read port of the table memory makes the scan read records in turn
// reset: the record count goes to zero, no clearing of the memory is needed.
// the receiver cannot stall: each result is valid only while done is high.
module sorted_insert_table_with_dup_check #(
  parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [15:0] athlete_id,
  input  logic [31:0] start_ms,
  input  logic [31:0] finish_ms,
  input  logic [3:0]  read_rank,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] out_id,
  output logic [31:0] out_start_ms,
  output logic [31:0] out_finish_ms,
  output logic [4:0]  entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = (CW > 4) ? CW : 4;
  localparam int EW = $bits(sit_pkg::entry_t);

  sit_pkg::state_t state, state_next;
  logic [CW-1:0]   fill, fill_next;
  logic [CW-1:0]   k, k_next;
  logic [CW-1:0]   pos, pos_next;
  logic            chk_valid, chk_valid_next;
  logic            req_action;
  sit_pkg::entry_t req, req_in;
  logic [3:0]      req_rank;

  logic            done_next;
  logic [2:0]      status_next;
  sit_pkg::entry_t res_next;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  sit_pkg::entry_t wdata, rdata;
  logic [EW-1:0]   rdata_raw;

  logic            accept;
  logic            issuing;
  logic            rank_ok;

  sit_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign rdata   = sit_pkg::entry_t'(rdata_raw);
  assign busy    = (state != sit_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign issuing = (k < fill);
  assign rank_ok = (RW'(req_rank) < RW'(fill));

  always_comb begin
    req_in.id        = athlete_id;
    req_in.start_ms  = start_ms;
    req_in.finish_ms = finish_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sit_pkg::S_IDLE;
      fill      <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      done      <= done_next;
      chk_valid <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k   <= k_next;
    pos <= pos_next;
    if (accept) begin
      req_action <= action;
      req        <= req_in;
      req_rank   <= read_rank;
    end
    if (done_next) begin
      status        <= status_next;
      out_id        <= res_next.id;
      out_start_ms  <= res_next.start_ms;
      out_finish_ms <= res_next.finish_ms;
      entry_count   <= 5'(fill_next);
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    k_next         = k;
    pos_next       = pos;
    chk_valid_next = 1'b0;
    done_next      = 1'b0;
    status_next    = sit_pkg::STATUS_INSERTED;
    res_next       = '0;
    we             = 1'b0;
    waddr          = AW'(pos);
    wdata          = req;
    raddr          = AW'(k);

    case (state)
      sit_pkg::S_IDLE: begin
        raddr = AW'(read_rank);
        if (accept) begin
          k_next = '0;
          if (action == sit_pkg::ACTION_READ) begin
            state_next = sit_pkg::S_RD_WAIT;
          end else begin
            state_next = sit_pkg::S_SCAN;
          end
        end
      end

      sit_pkg::S_SCAN: begin
        if (chk_valid && (rdata.id == req.id)) begin
          done_next   = 1'b1;
          status_next = sit_pkg::STATUS_DUPLICATE;
          state_next  = sit_pkg::S_IDLE;
        end else if (issuing) begin
          raddr          = AW'(k);
          k_next         = k + 1'b1;
          chk_valid_next = 1'b1;
        end else if (!chk_valid) begin
          if (fill == CW'(TABLE_DEPTH)) begin
            done_next   = 1'b1;
            status_next = sit_pkg::STATUS_FULL;
            state_next  = sit_pkg::S_IDLE;
          end else begin
            pos_next = fill;
            if (fill == '0) begin
              state_next = sit_pkg::S_SH_PUT;
            end else begin
              raddr      = AW'(fill - 1'b1);
              state_next = sit_pkg::S_SH_CMP;
            end
          end
        end
      end

      sit_pkg::S_SH_CMP: begin
        we    = 1'b1;
        waddr = AW'(pos);
        if (rdata.finish_ms > req.finish_ms) begin
          wdata    = rdata;
          pos_next = pos - 1'b1;
          if (pos == CW'(1)) begin
            state_next = sit_pkg::S_SH_PUT;
          end else begin
            raddr = AW'(pos - CW'(2));
          end
        end else begin
          wdata       = req;
          fill_next   = fill + 1'b1;
          done_next   = 1'b1;
          status_next = sit_pkg::STATUS_INSERTED;
          state_next  = sit_pkg::S_IDLE;
        end
      end

      sit_pkg::S_SH_PUT: begin
        we          = 1'b1;
        waddr       = AW'(pos);
        wdata       = req;
        fill_next   = fill + 1'b1;
        done_next   = 1'b1;
        status_next = sit_pkg::STATUS_INSERTED;
        state_next  = sit_pkg::S_IDLE;
      end

      sit_pkg::S_RD_WAIT: begin
        done_next  = 1'b1;
        state_next = sit_pkg::S_IDLE;
        if (rank_ok) begin
          status_next = sit_pkg::STATUS_READ_OK;
          res_next    = rdata;
        end else begin
          status_next = sit_pkg::STATUS_EMPTY;
        end
      end

      default: begin
        state_next = sit_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && (status == sit_pkg::STATUS_INSERTED)) |-> (fill == $past(fill) + 1'b1))
    else $error("insert without count increment");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (busy && (req_action == sit_pkg::ACTION_INSERT)))
    else $error("table write outside an insert");

  a_reject_keeps: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == sit_pkg::STATUS_DUPLICATE) || (status == sit_pkg::STATUS_FULL)))
      |-> (fill == $past(fill)))
    else $error("rejected insert changed the count");
`endif

endmodule

// File: hdl/sit_ram.sv
// sit_ram: generic single-write, single-read memory with registered read
// used for the record table storage
// no dependencies
module sit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: verif/sit_tb_pkg.sv
// sit_tb_pkg: result tracker for the sorted record table testbench
// predicts each request's reply from its own copy of the table and checks replies
// depends on sit_pkg
package sit_tb_pkg;
  import sit_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] id;
    logic [31:0] start_ms;
    logic [31:0] finish_ms;
    logic [4:0]  count;
  } reply_t;

  class ranked_table_tracker;
    entry_t      rows [TABLE_DEPTH_DEF];
    int unsigned held;
    reply_t      awaited [$];
    int unsigned faults;

    function new();
      held   = 0;
      faults = 0;
    endfunction

    function void report_fault(string what, reply_t want, reply_t got);
      faults++;
      if (faults <= 10) begin
        $display("mismatch (%s): want st=%0d id=%h s=%h f=%h n=%0d got st=%0d id=%h s=%h f=%h n=%0d",
                 what, want.status, want.id, want.start_ms, want.finish_ms, want.count,
                 got.status, got.id, got.start_ms, got.finish_ms, got.count);
      end
    endfunction

    function void note_request(logic act, logic [15:0] id, logic [31:0] st,
                               logic [31:0] fin, logic [3:0] rank);
      reply_t r;
      bit     dup;
      int     pos;
      r   = '0;
      dup = 0;
      if (act == ACTION_INSERT) begin
        for (int k = 0; k < held; k++) begin
          if (rows[k].id == id) dup = 1;
        end
        if (dup) begin
          r.status = STATUS_DUPLICATE;
        end else if (held >= TABLE_DEPTH_DEF) begin
          r.status = STATUS_FULL;
        end else begin
          pos = held;
          // equal finish times keep arrival order
          while (pos > 0 && rows[pos-1].finish_ms > fin) begin
            rows[pos] = rows[pos-1];
            pos--;
          end
          rows[pos].id        = id;
          rows[pos].start_ms  = st;
          rows[pos].finish_ms = fin;
          held++;
          r.status = STATUS_INSERTED;
        end
      end else begin
        if (rank < held) begin
          r.status    = STATUS_READ_OK;
          r.id        = rows[rank].id;
          r.start_ms  = rows[rank].start_ms;
          r.finish_ms = rows[rank].finish_ms;
        end else begin
          r.status = STATUS_EMPTY;
        end
      end
      r.count = held[4:0];
      awaited.push_back(r);
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (awaited.size() == 0) begin
        report_fault("no request pending", '0, got);
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status || got.id !== want.id ||
            got.start_ms !== want.start_ms || got.finish_ms !== want.finish_ms ||
            got.count !== want.count) begin
          report_fault("field", want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void close_out();
      while (awaited.size() > 0) begin
        report_fault("reply never came", awaited.pop_front(), '0);
      end
    endfunction
  endclass

endpackage

// File: verif/testbench.sv
// testbench: directed and random requests into the sorted record table
// replies are checked against ranked_table_tracker as they come out
// depends on sit_pkg, sit_tb_pkg and sorted_insert_table_with_dup_check
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sit_pkg::*;
  import sit_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic        action;
  logic [15:0] athlete_id;
  logic [31:0] start_ms;
  logic [31:0] finish_ms;
  logic [3:0]  read_rank;
  logic        done;
  logic [2:0]  status;
  logic [15:0] out_id;
  logic [31:0] out_start_ms;
  logic [31:0] out_finish_ms;
  logic [4:0]  entry_count;

  ranked_table_tracker tracker = new();
  bit quiet;

  sorted_insert_table_with_dup_check dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .athlete_id    (athlete_id),
    .start_ms      (start_ms),
    .finish_ms     (finish_ms),
    .read_rank     (read_rank),
    .done          (done),
    .status        (status),
    .out_id        (out_id),
    .out_start_ms  (out_start_ms),
    .out_finish_ms (out_finish_ms),
    .entry_count   (entry_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result({status, out_id, out_start_ms, out_finish_ms, entry_count});
    end
  end

  task automatic send_request(input logic act, input logic [15:0] id, input logic [31:0] st,
                              input logic [31:0] fin, input logic [3:0] rank);
    start      <= 1'b1;
    action     <= act;
    athlete_id <= id;
    start_ms   <= st;
    finish_ms  <= fin;
    read_rank  <= rank;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(act, id, st, fin, rank);
  endtask

  task automatic maybe_pause();
    int gap;
    if (!quiet && $urandom_range(99) < 18) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_finish();
    logic [31:0] f;
    case ($urandom_range(3))
      0: f = $urandom_range(0, 7);
      1: f = 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: f = (tracker.held > 0) ?
             tracker.rows[$urandom_range(tracker.held - 1)].finish_ms : $urandom;
      default: f = $urandom;
    endcase
    return f;
  endfunction

  task automatic directed_part();
    send_request(ACTION_READ, 16'h0000, 32'h0, 32'h0, 4'd0);
    maybe_pause();
    send_request(ACTION_READ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    maybe_pause();
    send_request(ACTION_INSERT, 16'h0000, 32'h0, 32'hFFFF_FFFF, 4'hF);
    maybe_pause();
    send_request(ACTION_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 4'h0);
    maybe_pause();
    send_request(ACTION_INSERT, 16'h1234, 32'd5, 32'd100, 4'hA);
    maybe_pause();
    // tie on finish time
    send_request(ACTION_INSERT, 16'h4321, 32'd6, 32'd100, 4'h5);
    maybe_pause();
    send_request(ACTION_INSERT, 16'h0777, 32'd7, 32'hFFFF_FFFF, 4'hF);
    maybe_pause();
    send_request(ACTION_INSERT, 16'h0000, 32'd9, 32'd50, 4'hF);
    maybe_pause();
    send_request(ACTION_INSERT, 16'hFFFF, 32'd1, 32'hFFFF_FFFF, 4'h0);
    maybe_pause();
    for (int r = 0; r < 6; r++) begin
      send_request(ACTION_READ, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'(r));
      maybe_pause();
    end
    send_request(ACTION_READ, 16'h0, 32'h0, 32'h0, 4'd15);
    maybe_pause();
    send_request(ACTION_INSERT, 16'hA5A5, 32'h5A5A_5A5A, 32'h0, 4'hF);
    maybe_pause();
    send_request(ACTION_READ, 16'h0, 32'h0, 32'h0, 4'd1);
    maybe_pause();
    send_request(ACTION_READ, 16'h0, 32'h0, 32'h0, 4'd6);
    maybe_pause();
  endtask

  task automatic random_part(input int n);
    int          pick;
    logic [15:0] id;
    logic [3:0]  rank;
    for (int i = 0; i < n; i++) begin
      quiet = (i >= 300 && i < 450);
      if (i == 500) begin
        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_request(ACTION_INSERT, 16'($urandom), $urandom, pick_finish(), 4'($urandom));
      end else if (pick < 24) begin
        id = (tracker.held > 0) ? tracker.rows[$urandom_range(tracker.held - 1)].id
                                : 16'($urandom);
        send_request(ACTION_INSERT, id, $urandom, pick_finish(), 4'($urandom));
      end else begin
        if ($urandom_range(1) == 0 || tracker.held == 0) begin
          rank = 4'($urandom);
        end else begin
          rank = 4'($urandom_range(tracker.held - 1));
        end
        send_request(ACTION_READ, 16'($urandom), $urandom, $urandom, rank);
      end
      maybe_pause();
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    action     = ACTION_INSERT;
    athlete_id = '0;
    start_ms   = '0;
    finish_ms  = '0;
    read_rank  = '0;
    quiet      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed_part();
    random_part(1000);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    tracker.close_out();
    if (tracker.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
hdl/sit_pkg.sv
hdl/sit_ram.sv
hdl/sorted_insert_table_with_dup_check.sv
verif/sit_tb_pkg.sv
verif/testbench.sv
